>>> src/ezr_pkg.sv
// ============================================================================
// Euler z-y-z rotation matrix: shared types and constants
// Fixed-point formats, the CORDIC arctangent table and the per-angle
// trigonometry record that moves along the chain of CORDIC cells.
// ============================================================================
package ezr_pkg;

   // Number of angles per item and their lane positions.
   localparam int NUM_ANGLES  = 3;
   localparam int ANGLE_ALPHA = 0;
   localparam int ANGLE_BETA  = 1;
   localparam int ANGLE_GAMMA = 2;

   // Internal datapath is Q2.30; the rotation lanes carry two guard bits.
   localparam int TRIG_FRAC  = 30;
   localparam int TRIG_BITS  = 32;
   localparam int Z_BITS     = 34;
   localparam int SUM_BITS   = 34;
   localparam int MAX_STAGES = 32;

   localparam logic signed [Z_BITS-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [Z_BITS-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [Z_BITS-1:0] GAIN_Q30    = 34'sd652032874;

   // atan(2^-i) in Q2.30.
   localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // One angle in flight: rotation vector, residual angle and quadrant flip.
   typedef struct packed {
      logic signed [Z_BITS-1:0] x;
      logic signed [Z_BITS-1:0] y;
      logic signed [Z_BITS-1:0] z;
      logic                     flip;
   } trig_lane_type;

   // All three angles of one item.
   typedef trig_lane_type [NUM_ANGLES-1:0] trig_row_type;

endpackage

>>> src/ezr_req_if.sv
// ============================================================================
// Euler z-y-z rotation matrix: request channel
// Valid/ready channel that carries one angle triple per item.
// ============================================================================
interface ezr_req_if #(
   parameter int ANGLE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] angle_alpha;
   logic signed [ANGLE_BITS-1:0] angle_beta;
   logic signed [ANGLE_BITS-1:0] angle_gamma;

   modport source (output valid, angle_alpha, angle_beta, angle_gamma, input ready);
   modport sink   (input valid, angle_alpha, angle_beta, angle_gamma, output ready);
endinterface

>>> src/ezr_rsp_if.sv
// ============================================================================
// Euler z-y-z rotation matrix: response channel
// Valid/ready channel that carries the nine matrix entries of one item.
// ============================================================================
interface ezr_rsp_if #(
   parameter int COEF_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [COEF_BITS-1:0] m00;
   logic signed [COEF_BITS-1:0] m01;
   logic signed [COEF_BITS-1:0] m02;
   logic signed [COEF_BITS-1:0] m10;
   logic signed [COEF_BITS-1:0] m11;
   logic signed [COEF_BITS-1:0] m12;
   logic signed [COEF_BITS-1:0] m20;
   logic signed [COEF_BITS-1:0] m21;
   logic signed [COEF_BITS-1:0] m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

>>> src/ezr_angle_fold.sv
// ============================================================================
// Euler z-y-z rotation matrix: angle entry stage
// Widens each angle to Q2.30, folds it into [-pi/2, pi/2] and seeds the
// CORDIC vector with the gain-compensated unit x.
// ============================================================================
module ezr_angle_fold #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ezr_req_if.sink               req,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ezr_pkg::trig_row_type out_row
);
   import ezr_pkg::*;

   // Angle fraction goes from ANGLE_BITS-3 bits to 30 bits.
   localparam int SCALE_SHIFT = TRIG_FRAC + 3 - ANGLE_BITS;

   logic signed [ANGLE_BITS-1:0] angle [NUM_ANGLES];
   trig_row_type                 row_in;
   trig_row_type                 row_ff;
   logic                         valid_ff;
   logic                         enable;

   assign angle[ANGLE_ALPHA] = req.angle_alpha;
   assign angle[ANGLE_BETA]  = req.angle_beta;
   assign angle[ANGLE_GAMMA] = req.angle_gamma;

   // Fold each angle by pi; the flip negates sine and cosine at the end.
   for (genvar k = 0; k < NUM_ANGLES; k++) begin : g_lane
      logic signed [Z_BITS-1:0] z_wide;

      assign z_wide = Z_BITS'(angle[k]) <<< SCALE_SHIFT;

      always_comb begin
         row_in[k].x    = GAIN_Q30;
         row_in[k].y    = '0;
         row_in[k].z    = z_wide;
         row_in[k].flip = 1'b0;
         if (z_wide > HALF_PI_Q30) begin
            row_in[k].z    = z_wide - PI_Q30;
            row_in[k].flip = 1'b1;
         end else if (z_wide < -HALF_PI_Q30) begin
            row_in[k].z    = z_wide + PI_Q30;
            row_in[k].flip = 1'b1;
         end
      end
   end

   // The stage loads when it is empty or its content moves on.
   assign enable    = !valid_ff || out_ready;
   assign req.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         row_ff <= row_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_row   = row_ff;

endmodule

>>> src/ezr_cordic_cell.sv
// ============================================================================
// Euler z-y-z rotation matrix: CORDIC cell
// One rotation-mode CORDIC iteration for all three angles of an item,
// followed by a register. Cells are chained, one per iteration.
// ============================================================================
module ezr_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  ezr_pkg::trig_row_type up_row,
   output logic                  down_valid,
   input  logic                  down_ready,
   output ezr_pkg::trig_row_type down_row
);
   import ezr_pkg::*;

   localparam logic signed [Z_BITS-1:0] STEP_ANGLE =
      Z_BITS'(signed'({1'b0, ATAN_TAB[STAGE]}));

   trig_row_type row_in;
   trig_row_type row_ff;
   logic         valid_ff;
   logic         enable;

   // Rotate toward zero residual angle; shifts floor.
   for (genvar k = 0; k < NUM_ANGLES; k++) begin : g_lane
      logic signed [Z_BITS-1:0] dx;
      logic signed [Z_BITS-1:0] dy;
      logic                     pos;

      assign dx  = up_row[k].y >>> STAGE;
      assign dy  = up_row[k].x >>> STAGE;
      assign pos = (up_row[k].z >= 0);

      assign row_in[k].x    = pos ? up_row[k].x - dx : up_row[k].x + dx;
      assign row_in[k].y    = pos ? up_row[k].y + dy : up_row[k].y - dy;
      assign row_in[k].z    = pos ? up_row[k].z - STEP_ANGLE : up_row[k].z + STEP_ANGLE;
      assign row_in[k].flip = up_row[k].flip;
   end

   // The cell loads when it is empty or its content moves on.
   assign enable   = !valid_ff || down_ready;
   assign up_ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         row_ff <= row_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_row   = row_ff;

endmodule

>>> src/ezr_matrix_combine.sv
// ============================================================================
// Euler z-y-z rotation matrix: matrix product stages
// Applies the quadrant flip, forms the two- and three-factor product terms
// over two multiplier stages, sums them, then rounds and saturates to the
// output format in the response register.
// ============================================================================
module ezr_matrix_combine #(
   parameter int COEF_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ezr_pkg::trig_row_type in_row,
   ezr_rsp_if.source             rsp
);
   import ezr_pkg::*;

   localparam int SHIFT     = TRIG_FRAC + 2 - COEF_BITS;
   localparam int RND_BITS  = SUM_BITS + 1;
   localparam int NUM_ELEMS = 9;

   // Matrix entry positions in the sum and result arrays.
   localparam int E00 = 0;
   localparam int E01 = 1;
   localparam int E02 = 2;
   localparam int E10 = 3;
   localparam int E11 = 4;
   localparam int E12 = 5;
   localparam int E20 = 6;
   localparam int E21 = 7;
   localparam int E22 = 8;

   localparam logic signed [RND_BITS-1:0] ONE     = RND_BITS'(1);
   localparam logic signed [RND_BITS-1:0] RND_ADD = (ONE <<< SHIFT) >>> 1;
   localparam logic signed [RND_BITS-1:0] LIM     = ONE <<< (COEF_BITS - 2);

   typedef logic signed [TRIG_BITS-1:0]   trig_type;
   typedef logic signed [2*TRIG_BITS-1:0] wide_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;

   // Q2.30 product floored back to Q2.30; magnitudes stay below two.
   function automatic trig_type qmul(trig_type a, trig_type b);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      return p[TRIG_FRAC+TRIG_BITS-1:TRIG_FRAC];
   endfunction

   // Final CORDIC value with the quadrant flip applied.
   function automatic trig_type unfold(logic signed [Z_BITS-1:0] v, logic flip);
      logic signed [Z_BITS-1:0] r;
      r = flip ? -v : v;
      return r[TRIG_BITS-1:0];
   endfunction

   // Round half up to the output fraction, then clamp to plus or minus one.
   function automatic coef_type to_coef(sum_type v);
      logic signed [RND_BITS-1:0] t;
      t = (RND_BITS'(v) + RND_ADD) >>> SHIFT;
      if (t > LIM) begin
         t = LIM;
      end else if (t < -LIM) begin
         t = -LIM;
      end
      return t[COEF_BITS-1:0];
   endfunction

   // Stage control: each stage loads when empty or when it drains.
   logic v_sc_ff, v_m1_ff, v_m2_ff, v_sum_ff, v_out_ff;
   logic en_sc, en_m1, en_m2, en_sum, en_out;

   assign en_out   = !v_out_ff || rsp.ready;
   assign en_sum   = !v_sum_ff || en_out;
   assign en_m2    = !v_m2_ff || en_sum;
   assign en_m1    = !v_m1_ff || en_m2;
   assign en_sc    = !v_sc_ff || en_m1;
   assign in_ready = en_sc;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_sc_ff  <= 1'b0;
         v_m1_ff  <= 1'b0;
         v_m2_ff  <= 1'b0;
         v_sum_ff <= 1'b0;
         v_out_ff <= 1'b0;
      end else begin
         if (en_sc) begin
            v_sc_ff <= in_valid;
         end
         if (en_m1) begin
            v_m1_ff <= v_sc_ff;
         end
         if (en_m2) begin
            v_m2_ff <= v_m1_ff;
         end
         if (en_sum) begin
            v_sum_ff <= v_m2_ff;
         end
         if (en_out) begin
            v_out_ff <= v_sum_ff;
         end
      end
   end

   // Sine and cosine of each angle.
   trig_type sa_ff, ca_ff, sb_ff, cb_ff, sg_ff, cg_ff;

   always_ff @(posedge clock) begin
      if (en_sc) begin
         sa_ff <= unfold(in_row[ANGLE_ALPHA].y, in_row[ANGLE_ALPHA].flip);
         ca_ff <= unfold(in_row[ANGLE_ALPHA].x, in_row[ANGLE_ALPHA].flip);
         sb_ff <= unfold(in_row[ANGLE_BETA].y, in_row[ANGLE_BETA].flip);
         cb_ff <= unfold(in_row[ANGLE_BETA].x, in_row[ANGLE_BETA].flip);
         sg_ff <= unfold(in_row[ANGLE_GAMMA].y, in_row[ANGLE_GAMMA].flip);
         cg_ff <= unfold(in_row[ANGLE_GAMMA].x, in_row[ANGLE_GAMMA].flip);
      end
   end

   // First products: all two-factor terms and the alpha-beta partials.
   trig_type cacb_ff, sacb_ff, sasg_ff, sacg_ff, casb_ff;
   trig_type casg_ff, cacg_ff, sasb_ff, sbcg_ff, sbsg_ff;
   trig_type sg1_ff, cg1_ff, cb1_ff;

   always_ff @(posedge clock) begin
      if (en_m1) begin
         cacb_ff <= qmul(ca_ff, cb_ff);
         sacb_ff <= qmul(sa_ff, cb_ff);
         sasg_ff <= qmul(sa_ff, sg_ff);
         sacg_ff <= qmul(sa_ff, cg_ff);
         casb_ff <= qmul(ca_ff, sb_ff);
         casg_ff <= qmul(ca_ff, sg_ff);
         cacg_ff <= qmul(ca_ff, cg_ff);
         sasb_ff <= qmul(sa_ff, sb_ff);
         sbcg_ff <= qmul(sb_ff, cg_ff);
         sbsg_ff <= qmul(sb_ff, sg_ff);
         sg1_ff  <= sg_ff;
         cg1_ff  <= cg_ff;
         cb1_ff  <= cb_ff;
      end
   end

   // Second products: the three-factor terms; two-factor terms ride along.
   trig_type cacbcg_ff, cacbsg_ff, sacbcg_ff, sacbsg_ff;
   trig_type sasg2_ff, sacg2_ff, casb2_ff, casg2_ff, cacg2_ff;
   trig_type sasb2_ff, sbcg2_ff, sbsg2_ff, cb2_ff;

   always_ff @(posedge clock) begin
      if (en_m2) begin
         cacbcg_ff <= qmul(cacb_ff, cg1_ff);
         cacbsg_ff <= qmul(cacb_ff, sg1_ff);
         sacbcg_ff <= qmul(sacb_ff, cg1_ff);
         sacbsg_ff <= qmul(sacb_ff, sg1_ff);
         sasg2_ff  <= sasg_ff;
         sacg2_ff  <= sacg_ff;
         casb2_ff  <= casb_ff;
         casg2_ff  <= casg_ff;
         cacg2_ff  <= cacg_ff;
         sasb2_ff  <= sasb_ff;
         sbcg2_ff  <= sbcg_ff;
         sbsg2_ff  <= sbsg_ff;
         cb2_ff    <= cb1_ff;
      end
   end

   // Exact sums of the product terms.
   sum_type sum_ff [NUM_ELEMS];

   always_ff @(posedge clock) begin
      if (en_sum) begin
         sum_ff[E00] <= SUM_BITS'(cacbcg_ff) - SUM_BITS'(sasg2_ff);
         sum_ff[E01] <= -SUM_BITS'(cacbsg_ff) - SUM_BITS'(sacg2_ff);
         sum_ff[E02] <= SUM_BITS'(casb2_ff);
         sum_ff[E10] <= SUM_BITS'(sacbcg_ff) + SUM_BITS'(casg2_ff);
         sum_ff[E11] <= -SUM_BITS'(sacbsg_ff) + SUM_BITS'(cacg2_ff);
         sum_ff[E12] <= SUM_BITS'(sasb2_ff);
         sum_ff[E20] <= -SUM_BITS'(sbcg2_ff);
         sum_ff[E21] <= SUM_BITS'(sbsg2_ff);
         sum_ff[E22] <= SUM_BITS'(cb2_ff);
      end
   end

   // Response register: rounded and saturated entries.
   coef_type coef_ff [NUM_ELEMS];

   for (genvar e = 0; e < NUM_ELEMS; e++) begin : g_elem
      always_ff @(posedge clock) begin
         if (en_out) begin
            coef_ff[e] <= to_coef(sum_ff[e]);
         end
      end
   end

   assign rsp.valid = v_out_ff;
   assign rsp.m00   = coef_ff[E00];
   assign rsp.m01   = coef_ff[E01];
   assign rsp.m02   = coef_ff[E02];
   assign rsp.m10   = coef_ff[E10];
   assign rsp.m11   = coef_ff[E11];
   assign rsp.m12   = coef_ff[E12];
   assign rsp.m20   = coef_ff[E20];
   assign rsp.m21   = coef_ff[E21];
   assign rsp.m22   = coef_ff[E22];

endmodule

>>> src/euler_zyz_rotation_matrix_top.sv
// ============================================================================
// Euler z-y-z rotation matrix
// Top level: angle entry stage, chain of CORDIC cells, matrix product stages.
// ============================================================================
// Takes three z-y-z Euler angles (signed Q3.(ANGLE_BITS-3) radians) per item
// and returns the nine entries of Rz(alpha)*Ry(beta)*Rz(gamma) as signed
// Q2.(COEF_BITS-2) values, rounded half up and saturated to plus or minus one.
// The block is fully pipelined and accepts one item every cycle while the
// pipeline is not full. Each item passes TRIG_STAGES + 6 registers: the entry
// stage, one CORDIC cell per iteration (at most 32 are used), and the flip,
// two multiplier, sum and output stages. The accepting edge loads the first of
// them. Every stage holds its item only while the next one is full, so a
// stalled response blocks input only once the whole pipeline is occupied.
// The block keeps no state between items.
module euler_zyz_rotation_matrix_top #(
   parameter int ANGLE_BITS  = 16,
   parameter int COEF_BITS   = 16,
   parameter int TRIG_STAGES = 16
) (
   input  logic      clock,
   input  logic      reset,
   ezr_req_if.sink   req,
   ezr_rsp_if.source rsp
);
   import ezr_pkg::*;

   localparam int N_STAGES = (TRIG_STAGES > MAX_STAGES) ? MAX_STAGES : TRIG_STAGES;

   // Links between neighbors in the CORDIC chain; link 0 is the entry stage.
   logic         link_valid [N_STAGES+1];
   logic         link_ready [N_STAGES+1];
   trig_row_type link_row   [N_STAGES+1];

   ezr_angle_fold #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_row   (link_row[0])
   );

   // One cell per CORDIC iteration.
   for (genvar i = 0; i < N_STAGES; i++) begin : g_cell
      ezr_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[i]),
         .up_ready   (link_ready[i]),
         .up_row     (link_row[i]),
         .down_valid (link_valid[i+1]),
         .down_ready (link_ready[i+1]),
         .down_row   (link_row[i+1])
      );
   end

   ezr_matrix_combine #(
      .COEF_BITS (COEF_BITS)
   ) u_combine (
      .clock    (clock),
      .reset    (reset),
      .in_valid (link_valid[N_STAGES]),
      .in_ready (link_ready[N_STAGES]),
      .in_row   (link_row[N_STAGES]),
      .rsp      (rsp)
   );

endmodule

>>> sim/euler_zyz_rotation_matrix_top_test.sv
// ============================================================================
// Euler z-y-z rotation matrix: block-level test
// Drives angle triples into the rotation matrix block and compares each matrix
// it returns with a bit-exact CORDIC and fixed-point product predictor. The run
// covers corner angles, random angles, back-to-back traffic, a long output
// stall and a pause until the pipeline has drained.
// ============================================================================
module euler_zyz_rotation_matrix_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS  = 16;
   localparam int COEF_BITS   = 16;
   localparam int TRIG_STAGES = 16;
   localparam int LATENCY     = TRIG_STAGES + 5;
   localparam int CYCLE_LIMIT = 300000;

   // Q2.30 constants of the trigonometry datapath.
   localparam longint PI_FIX      = 64'sd3373259426;
   localparam longint HALF_PI_FIX = 64'sd1686629713;
   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam logic [31:0] ATAN_STEP [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // Angle codes in Q3.13 around the folding boundaries.
   localparam logic signed [15:0] ANGLE_HALF_PI = 16'sd12868;
   localparam logic signed [15:0] ANGLE_PI      = 16'sd25736;

   // Nine matrix entries, index 0 is m00 and index 8 is m22.
   typedef logic [8:0][COEF_BITS-1:0] matrix_type;

   logic clock = 1'b0;
   logic reset;

   ezr_req_if #(.ANGLE_BITS(ANGLE_BITS)) req_bus ();
   ezr_rsp_if #(.COEF_BITS(COEF_BITS))   rsp_bus ();

   euler_zyz_rotation_matrix_top #(
      .ANGLE_BITS (ANGLE_BITS),
      .COEF_BITS  (COEF_BITS),
      .TRIG_STAGES(TRIG_STAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   matrix_type pending_matrices [$];
   string   entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                               "m20", "m21", "m22"};
   int      fail_count;
   int      triples_sent;
   int      matrices_checked;
   int      cycle_count;
   int      stall_cycles;
   bit      sender_idles;
   bit      receiver_idles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sine and cosine of one angle in Q2.30 by folded rotation-mode CORDIC.
   function automatic void cordic_sin_cos(input logic signed [ANGLE_BITS-1:0] angle,
                                          output longint sine, output longint cosine);
      longint x, y, z, dx, dy;
      bit     flip;
      int     i;
      z = longint'(angle) * (64'sd1 <<< (33 - ANGLE_BITS));
      x = CORDIC_GAIN;
      y = 0;
      flip = 1'b0;
      if (z > HALF_PI_FIX) begin
         z = z - PI_FIX;
         flip = 1'b1;
      end else if (z < -HALF_PI_FIX) begin
         z = z + PI_FIX;
         flip = 1'b1;
      end
      for (i = 0; i < TRIG_STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_STEP[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_STEP[i]);
         end
      end
      cosine = flip ? -x : x;
      sine   = flip ? -y : y;
   endfunction

   // Q2.30 product, floored.
   function automatic longint fix_mul(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   // Round half up to Q2.14 and saturate to plus or minus one.
   function automatic logic [COEF_BITS-1:0] to_coef(input longint v);
      longint r, lim;
      lim = 64'sd1 <<< (COEF_BITS - 2);
      r = (v + (64'sd1 <<< (29 - COEF_BITS + 2))) >>> (32 - COEF_BITS);
      if (r > lim)  r = lim;
      if (r < -lim) r = -lim;
      return r[COEF_BITS-1:0];
   endfunction

   // Rz(alpha) * Ry(beta) * Rz(gamma) as the block forms it.
   function automatic matrix_type zyz_matrix(input logic signed [ANGLE_BITS-1:0] alpha,
                                             input logic signed [ANGLE_BITS-1:0] beta,
                                             input logic signed [ANGLE_BITS-1:0] gamma);
      longint     sa, ca, sb, cb, sg, cg, cacb, sacb;
      matrix_type m;
      cordic_sin_cos(alpha, sa, ca);
      cordic_sin_cos(beta, sb, cb);
      cordic_sin_cos(gamma, sg, cg);
      cacb = fix_mul(ca, cb);
      sacb = fix_mul(sa, cb);
      m[0] = to_coef(fix_mul(cacb, cg) - fix_mul(sa, sg));
      m[1] = to_coef(-fix_mul(cacb, sg) - fix_mul(sa, cg));
      m[2] = to_coef(fix_mul(ca, sb));
      m[3] = to_coef(fix_mul(sacb, cg) + fix_mul(ca, sg));
      m[4] = to_coef(-fix_mul(sacb, sg) + fix_mul(ca, cg));
      m[5] = to_coef(fix_mul(sa, sb));
      m[6] = to_coef(-fix_mul(sb, cg));
      m[7] = to_coef(fix_mul(sb, sg));
      m[8] = to_coef(cb);
      return m;
   endfunction

   // Predict on every accepted triple; check every accepted matrix in order.
   always @(posedge clock) begin : matrix_scoreboard
      matrix_type got, want;
      int         k;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pending_matrices.push_back(zyz_matrix(req_bus.angle_alpha,
                                                  req_bus.angle_beta,
                                                  req_bus.angle_gamma));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got[0] = rsp_bus.m00;
            got[1] = rsp_bus.m01;
            got[2] = rsp_bus.m02;
            got[3] = rsp_bus.m10;
            got[4] = rsp_bus.m11;
            got[5] = rsp_bus.m12;
            got[6] = rsp_bus.m20;
            got[7] = rsp_bus.m21;
            got[8] = rsp_bus.m22;
            if (pending_matrices.size() == 0) begin
               $error("matrix item arrived with no angle triple pending");
               fail_count++;
            end else begin
               want = pending_matrices.pop_front();
               for (k = 0; k < 9; k++) begin
                  if (got[k] !== want[k]) begin
                     $error("%s: expected %0d, actual %0d", entry_name[k],
                            $signed(want[k]), $signed(got[k]));
                     fail_count++;
                  end
               end
               matrices_checked++;
            end
         end
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("euler_zyz_rotation_matrix_top_test NOT OK");
         $finish;
      end
   end

   // Result side: a long hold-off on request, otherwise random waits per item while receiver_idles is set.
   initial begin : matrix_receiver
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (stall_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall_cycles) @(posedge clock);
            stall_cycles = 0;
         end
         gap = receiver_idles ? $urandom_range(0, 9) : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Offer one angle triple and return at the edge that accepts it.
   task automatic offer_angles(input logic signed [ANGLE_BITS-1:0] alpha,
                               input logic signed [ANGLE_BITS-1:0] beta,
                               input logic signed [ANGLE_BITS-1:0] gamma);
      int gap;
      gap = sender_idles ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.angle_alpha <= alpha;
      req_bus.angle_beta  <= beta;
      req_bus.angle_gamma <= gamma;
      do @(posedge clock); while (!req_bus.ready);
      triples_sent++;
   endtask

   // Mostly uniform codes, sometimes just around zero, pi/2 or pi.
   function automatic logic signed [ANGLE_BITS-1:0] draw_angle();
      int base;
      if ($urandom_range(0, 9) < 7) return ANGLE_BITS'($urandom);
      case ($urandom_range(0, 4))
         0:       base = 0;
         1:       base = ANGLE_HALF_PI;
         2:       base = -ANGLE_HALF_PI;
         3:       base = ANGLE_PI;
         default: base = -ANGLE_PI;
      endcase
      base = base + int'($urandom_range(0, 8)) - 4;
      return base[ANGLE_BITS-1:0];
   endfunction

   // Drop valid and wait until every pending matrix has come back.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_matrices.size() != 0) @(posedge clock);
   endtask

   // Field extremes and both sides of the folding boundaries.
   task automatic test_corner_angles();
      logic signed [ANGLE_BITS-1:0] corner [10] = '{
         16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
         16'sd12867, 16'sd12868, -16'sd12867, -16'sd12868, 16'sd25736
      };
      int i;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      for (i = 0; i < 10; i++) begin
         offer_angles(corner[i], corner[i], corner[i]);
         offer_angles(corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10]);
      end
      offer_angles('0, ANGLE_HALF_PI, '0);
      offer_angles('0, -ANGLE_HALF_PI, '0);
      offer_angles(ANGLE_PI, ANGLE_PI, -ANGLE_PI);
      offer_angles(-ANGLE_PI, '0, ANGLE_PI);
   endtask

   // Random triples with random gaps on both sides.
   task automatic test_random_angles(input int count);
      int i;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      for (i = 0; i < count; i++) offer_angles(draw_angle(), draw_angle(), draw_angle());
   endtask

   // Full rate in both directions.
   task automatic test_back_to_back(input int count);
      int i;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      for (i = 0; i < count; i++) offer_angles(draw_angle(), draw_angle(), draw_angle());
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall input.
   task automatic test_output_stall(input int count);
      int i;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      stall_cycles   = 4 * LATENCY;
      for (i = 0; i < count; i++) offer_angles(draw_angle(), draw_angle(), draw_angle());
   endtask

   // Bursts separated by a full drain of the pipeline.
   task automatic test_drain_pause(input int count);
      int i;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      for (i = 0; i < count; i++) offer_angles(draw_angle(), draw_angle(), draw_angle());
      drain_pipeline();
      sender_idles = 1'b0;
      for (i = 0; i < count; i++) offer_angles(draw_angle(), draw_angle(), draw_angle());
      drain_pipeline();
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.angle_alpha <= '0;
      req_bus.angle_beta  <= '0;
      req_bus.angle_gamma <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_corner_angles();
      test_random_angles(560);
      test_back_to_back(100);
      test_output_stall(60);
      test_drain_pause(30);
      test_random_angles(40);

      // Wait out the pipeline, then allow stray results to show up.
      req_bus.valid <= 1'b0;
      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (pending_matrices.size() != 0) begin
         $error("%0d matrices never arrived", pending_matrices.size());
         fail_count++;
      end

      $display("Sent %0d angle triples and checked %0d matrices", triples_sent,
               matrices_checked);
      $display("over corner, random, full-rate, output-stall and drain phases.");
      if (fail_count == 0) begin
         $display("euler_zyz_rotation_matrix_top_test OK");
      end else begin
         $display("euler_zyz_rotation_matrix_top_test NOT OK");
      end
      $finish;
   end

endmodule
